>>> src/edf_pkg.sv
// Shared types and constants for the EDF periodic task scheduler.
package edf_pkg;

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned SLACK_W = 18;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned ROW_W   = 2 * DATA_W + SLACK_W;
  localparam int unsigned TAB_W   = 3 * DATA_W;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic signed [SLACK_W-1:0] SLACK_MIN = 18'sh20000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } edf_state_e;

  typedef struct packed {
    logic load;
    logic start;
    logic rd_en;
    logic proc;
    logic commit;
  } edf_cmd_t;

  typedef struct packed {
    logic more;
  } edf_sts_t;

endpackage

>>> src/edf_req_if.sv
// Request channel carrying load and tick items into the scheduler.
interface edf_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [2:0]  task_slot;
  logic [15:0] exec_time;
  logic [15:0] period_ticks;
  logic [15:0] rel_deadline;

  modport source (output valid, op, task_slot, exec_time, period_ticks, rel_deadline,
                  input ready);
  modport sink (input valid, op, task_slot, exec_time, period_ticks, rel_deadline,
                output ready);
endinterface

>>> src/edf_rsp_if.sv
// Result channel carrying the per-tick scheduling decision.
interface edf_rsp_if;
  logic       valid;
  logic       ready;
  logic       cpu_busy;
  logic [2:0] running_slot;

  modport source (output valid, cpu_busy, running_slot, input ready);
  modport sink (input valid, cpu_busy, running_slot, output ready);
endinterface

>>> src/edf_ctrl.sv
// Controller state machine sequencing loads, slot scans and result hand-off.
module edf_ctrl
  import edf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_op_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output edf_cmd_t cmd_o,
  input  edf_sts_t sts_i
);

  edf_state_e state_q, state_d;
  logic       pv_q, pv_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    pv_d       = 1'b0;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == OP_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en = sts_i.more;
        cmd_o.proc  = pv_q;
        pv_d        = sts_i.more;
        if (!sts_i.more && !pv_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/edf_dp.sv
// Datapath: task tables, per-slot state memories, slot counter and min-slack tracker.
module edf_dp
  import edf_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  edf_cmd_t           cmd_i,
  output edf_sts_t           sts_o,
  input  logic               cfg_we_i,
  input  logic [CNT_W-1:0]   cfg_wdata_i,
  input  logic [SLOT_W-1:0]  task_slot_i,
  input  logic [DATA_W-1:0]  exec_time_i,
  input  logic [DATA_W-1:0]  period_ticks_i,
  input  logic [DATA_W-1:0]  rel_deadline_i,
  output logic               cpu_busy_o,
  output logic [SLOT_W-1:0]  running_slot_o
);

  localparam int unsigned SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned NW = (CW > CNT_W) ? CW : CNT_W;
  localparam int unsigned XW = SW + SLOT_W;
  localparam logic [NW-1:0] SLOTS_N = NW'(MAX_SLOTS);
  localparam logic [XW-1:0] SLOTS_X = XW'(MAX_SLOTS);

  logic [CNT_W-1:0] task_count_q;
  logic [NW-1:0]    n_act;
  logic [NW-1:0]    cnt_q;
  logic [SW-1:0]    rd_addr;
  logic [SW-1:0]    proc_idx_q;

  logic [TAB_W-1:0] tab_mem [MAX_SLOTS];
  logic [ROW_W-1:0] row_mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] row_vld_q;
  logic [TAB_W-1:0] tab_rd_q;
  logic [ROW_W-1:0] row_rd_q;
  logic             vld_rd_q;

  logic [XW-1:0]    slot_ext;
  logic [SW-1:0]    load_addr;
  logic             load_ok;
  logic [DATA_W-1:0] period_n;

  logic             row_we;
  logic [SW-1:0]    row_waddr;
  logic [ROW_W-1:0] row_wdata;

  logic [ROW_W-1:0] row_cur;
  logic [DATA_W-1:0] work_c, phase_c, exec_c, period_c, deadline_c;
  logic signed [SLACK_W-1:0] slack_c;
  logic              released;
  logic [DATA_W-1:0] work_r, phase_r, phase_a;
  logic signed [SLACK_W-1:0] slack_r, slack_a;
  logic              take;

  logic              found_q;
  logic [SW-1:0]     best_idx_q;
  logic signed [SLACK_W-1:0] best_slack_q;
  logic [ROW_W-1:0]  best_row_q;
  logic [XW-1:0]     best_ext;
  logic              busy_q;
  logic [SLOT_W-1:0] slot_q;

  // Active slot count, saturated to the number of slots built.
  assign n_act = (NW'(task_count_q) > SLOTS_N) ? SLOTS_N : NW'(task_count_q);
  assign sts_o.more = (cnt_q < n_act);
  assign rd_addr = cnt_q[SW-1:0];

  assign slot_ext  = XW'(task_slot_i);
  assign load_addr = slot_ext[SW-1:0];
  assign load_ok   = (slot_ext < SLOTS_X);
  assign period_n  = (period_ticks_i == '0) ? DATA_W'(1) : period_ticks_i;

  // Row layout: {work, slack, phase}. Rows never written read as zero.
  assign row_cur    = vld_rd_q ? row_rd_q : '0;
  assign work_c     = row_cur[ROW_W-1 -: DATA_W];
  assign slack_c    = $signed(row_cur[DATA_W +: SLACK_W]);
  assign phase_c    = row_cur[DATA_W-1:0];
  assign exec_c     = tab_rd_q[TAB_W-1 -: DATA_W];
  assign period_c   = tab_rd_q[DATA_W +: DATA_W];
  assign deadline_c = tab_rd_q[DATA_W-1:0];

  always_comb begin
    released = (phase_c == '0);
    work_r   = released ? exec_c : work_c;
    slack_r  = released ? $signed({{(SLACK_W - DATA_W){1'b0}}, deadline_c}) : slack_c;
    phase_r  = released ? ((period_c == '0) ? DATA_W'(1) : period_c) : phase_c;
    slack_a  = (slack_r > SLACK_MIN) ? (slack_r - 18'sd1) : slack_r;
    phase_a  = phase_r - DATA_W'(1);
    take     = cmd_i.proc && (work_r != '0) && (!found_q || (slack_r < best_slack_q));
  end

  // Single write port into the state rows: load, scan write-back or commit.
  always_comb begin
    row_we    = 1'b0;
    row_waddr = proc_idx_q;
    row_wdata = {work_r, slack_a, phase_a};
    if (cmd_i.load) begin
      row_we    = load_ok;
      row_waddr = load_addr;
      row_wdata = '0;
    end else if (cmd_i.proc) begin
      row_we = 1'b1;
    end else if (cmd_i.commit) begin
      row_we    = found_q;
      row_waddr = best_idx_q;
      row_wdata = best_row_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && load_ok) begin
      tab_mem[load_addr] <= {exec_time_i, period_n, rel_deadline_i};
    end
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    if (cmd_i.rd_en) begin
      tab_rd_q   <= tab_mem[rd_addr];
      row_rd_q   <= row_mem[rd_addr];
      proc_idx_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= '0;
      row_vld_q    <= '0;
      vld_rd_q     <= 1'b0;
      cnt_q        <= '0;
      found_q      <= 1'b0;
      busy_q       <= 1'b0;
      slot_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        task_count_q <= cfg_wdata_i;
      end
      if (row_we) begin
        row_vld_q[row_waddr] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        vld_rd_q <= row_vld_q[rd_addr];
      end
      if (cmd_i.start) begin
        cnt_q <= '0;
      end else if (cmd_i.rd_en) begin
        cnt_q <= cnt_q + NW'(1);
      end
      if (cmd_i.start) begin
        found_q <= 1'b0;
      end else if (take) begin
        found_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        busy_q <= found_q;
        slot_q <= found_q ? best_ext[SLOT_W-1:0] : '0;
      end
    end
  end

  // The winner's row is kept already aged and with its work decremented.
  always_ff @(posedge clk_i) begin
    if (take) begin
      best_idx_q   <= proc_idx_q;
      best_slack_q <= slack_r;
      best_row_q   <= {work_r - DATA_W'(1), slack_a, phase_a};
    end
  end

  assign best_ext       = XW'(best_idx_q);
  assign cpu_busy_o     = busy_q;
  assign running_slot_o = slot_q;

endmodule

>>> src/edf_periodic_task_scheduler_top.sv
// Top level of the earliest-deadline-first periodic task scheduler.
// This block schedules up to MAX_SLOTS periodic tasks by earliest deadline first.
// A load request (op 0) writes one slot's execution time, period and relative
// deadline, clears its remaining work and slack and restarts its phase so that
// it releases on the next tick; a load gives no result.
// A load to a slot at or above MAX_SLOTS is dropped, and a period of zero is
// stored as one. A tick request (op 1) releases every active slot whose phase
// has run out, runs the ready slot with the least slack (lowest slot on a tie),
// ages all active slots by one tick and returns one result: cpu_busy and the
// running slot, or idle with slot 0. The user must write the task_count register
// through cfg_we_i/cfg_wdata_i only while the block is idle; the block does not
// enforce this. task_count selects how many slots take part; values above
// MAX_SLOTS act as MAX_SLOTS. A tick walks the active slots one per cycle through
// a state memory with one write port and a registered read. The result sits in
// an output register; a new request is taken while it waits, and a following
// tick only holds in its final step until the earlier result has been taken.
// Slots never loaded must not be activated; their table contents are undefined.
module edf_periodic_task_scheduler_top
  import edf_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  edf_req_if.sink          req_i,
  edf_rsp_if.source        rsp_o,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i
);

  edf_cmd_t cmd;
  edf_sts_t sts;

  // The controller owns the handshakes and the step sequence of a tick.
  edf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_op_i     (req_i.op),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // The datapath holds the tables, the per-slot state and the selection logic.
  edf_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .task_slot_i    (req_i.task_slot),
    .exec_time_i    (req_i.exec_time),
    .period_ticks_i (req_i.period_ticks),
    .rel_deadline_i (req_i.rel_deadline),
    .cpu_busy_o     (rsp_o.cpu_busy),
    .running_slot_o (rsp_o.running_slot)
  );

  // A tick request occupies the block: it cannot accept again on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.op == OP_TICK) |=> !req_i.ready)
    else $error("request accepted while a tick scan was in progress");

  // A load request never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.op == OP_LOAD && !rsp_o.valid) |=> !rsp_o.valid)
    else $error("result appeared after a load request");

  // An idle tick always reports slot zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.cpu_busy) |-> (rsp_o.running_slot == '0))
    else $error("idle result carries a nonzero slot");

endmodule

>>> tb/sv/edf_periodic_task_scheduler_top_tb.sv
// Self-checking testbench for the EDF periodic task scheduler top level.
`timescale 1ns / 1ps

module edf_periodic_task_scheduler_top_tb;
  import edf_pkg::*;

  // The block is built with its default of eight slots. The predictor below keeps
  // its own copy of every table at that depth.
  localparam int NUM_SLOTS = 8;

  // The slack counters are 18-bit two's complement and stop at the most negative
  // value instead of wrapping around. The predictor keeps them as plain ints.
  localparam int SLACK_FLOOR = int'(SLACK_MIN);

  // This margin covers any request still in flight after the last result came back.
  localparam int SETTLE_CYCLES = 16;

  // The slowest legal run is about 2000 requests. Each one can cost a full scan,
  // a sender gap and a receiver stall. The limit is several times that total.
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Length of the long receiver hold-off that fills the pipeline and stalls the
  // request channel.
  localparam int HOLD_OFF_CYCLES = 300;

  localparam int RAND_PHASES     = 12;
  localparam int REQS_PER_PHASE  = 160;

  // One scheduling decision, which is what a tick request returns.
  typedef struct packed {
    logic              busy;
    logic [SLOT_W-1:0] slot;
  } sched_decision_t;

  // Rows of the directed table are either a request or a task_count write.
  typedef enum logic [1:0] {
    ROW_LOAD,
    ROW_TICK,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] exec_t;
    logic [DATA_W-1:0] period_t;
    logic [DATA_W-1:0] dline_t;
    logic [CNT_W-1:0]  cnt;
    logic              typed;     // a hand-written expectation replaces the predictor
    logic              exp_busy;
    logic [SLOT_W-1:0] exp_slot;
  } dir_row_t;

  // The directed part runs in a fixed order. With task_count at zero a tick has to
  // come back idle, both right after reset and after every slot is loaded. Loading
  // all eight slots before any of them is activated keeps every later setting away
  // from unwritten table entries. The loads cover zero and full-scale execution
  // time, zero and full-scale period (zero behaves as one) and deadlines from zero
  // to full scale. With one active slot, slot 0 has one tick of work and a period
  // of one, so it runs on every tick. A count of 15 has to act as eight, and a
  // count of 9 as well. Slot 0 is also reloaded while it is active, which restarts
  // its phase.
  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{ROW_CFG,  3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0,  1'b0, 1'b0, 3'd0},
    '{ROW_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0,  1'b1, 1'b0, 3'd0},
    '{ROW_LOAD, 3'd0, 16'h0001, 16'h0000, 16'h0000, 4'd0,  1'b0, 1'b0, 3'd0},
    '{ROW_LOAD, 3'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd0,  1'b0, 1'b0, 3'd0},
    '{ROW_LOAD, 3'd2, 16'h0000, 16'h0005, 16'h0003, 4'd0,  1'b0, 1'b0, 3'd0},
    '{ROW_LOAD, 3'd3, 16'h0003, 16'h0004, 16'h0002, 4'd0,  1'b0, 1'b0, 3'd0},
    '{ROW_LOAD, 3'd4, 16'h0002, 16'h0000, 16'h0000, 4'd0,  1'b0, 1'b0, 3'd0},
    '{ROW_LOAD, 3'd5, 16'hAAAA, 16'h5555, 16'h5555, 4'd0,  1'b0, 1'b0, 3'd0},
    '{ROW_LOAD, 3'd6, 16'h0001, 16'h0003, 16'h0001, 4'd0,  1'b0, 1'b0, 3'd0},
    '{ROW_LOAD, 3'd7, 16'h0005, 16'h0009, 16'h8000, 4'd0,  1'b0, 1'b0, 3'd0},
    '{ROW_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0,  1'b1, 1'b0, 3'd0},
    '{ROW_CFG,  3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd1,  1'b0, 1'b0, 3'd0},
    '{ROW_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0,  1'b1, 1'b1, 3'd0},
    '{ROW_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0,  1'b1, 1'b1, 3'd0},
    '{ROW_CFG,  3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd15, 1'b0, 1'b0, 3'd0},
    '{ROW_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0,  1'b0, 1'b0, 3'd0},
    '{ROW_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0,  1'b0, 1'b0, 3'd0},
    '{ROW_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0,  1'b0, 1'b0, 3'd0},
    '{ROW_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0,  1'b0, 1'b0, 3'd0},
    '{ROW_LOAD, 3'd0, 16'h0004, 16'h0002, 16'h0001, 4'd0,  1'b0, 1'b0, 3'd0},
    '{ROW_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0,  1'b0, 1'b0, 3'd0},
    '{ROW_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0,  1'b0, 1'b0, 3'd0},
    '{ROW_CFG,  3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd9,  1'b0, 1'b0, 3'd0},
    '{ROW_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0,  1'b0, 1'b0, 3'd0},
    '{ROW_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0,  1'b0, 1'b0, 3'd0}
  };

  // The first phases of the random part walk through fixed counts, including zero,
  // one, the full eight and a value that has to saturate. Later phases pick counts
  // at random.
  localparam logic [CNT_W-1:0] CNT_PLAN [6] = '{4'd8, 4'd1, 4'd15, 4'd3, 4'd0, 4'd5};

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;

  edf_req_if req_if ();
  edf_rsp_if rsp_if ();

  edf_periodic_task_scheduler_top #(
    .MAX_SLOTS (NUM_SLOTS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // This is the predictor's view of the scheduler state, with the same widths as
  // the hardware. Slack is the exception and is kept as an int.
  logic [CNT_W-1:0]  task_cnt_q;
  logic [DATA_W-1:0] exec_tab     [NUM_SLOTS];
  logic [DATA_W-1:0] period_tab   [NUM_SLOTS];
  logic [DATA_W-1:0] deadline_tab [NUM_SLOTS];
  logic [DATA_W-1:0] work_tab     [NUM_SLOTS];
  int                slack_tab    [NUM_SLOTS];
  logic [DATA_W-1:0] phase_tab    [NUM_SLOTS];

  // Decisions predicted for accepted ticks, in the order they must come back.
  sched_decision_t decision_q [$];

  int unsigned fail_count;
  int unsigned cycle_cnt;
  logic        idle_on;          // random gaps on both channels are allowed
  logic        hold_off_req;     // asks the receiver for one long hold-off
  int          hold_off_left;
  int          stall_left;

  // A load writes one slot and clears its running state. A clear phase makes the
  // slot release on the very next tick in which it is active.
  function automatic void sched_load(input logic [SLOT_W-1:0] slot,
                                     input logic [DATA_W-1:0] exec_t,
                                     input logic [DATA_W-1:0] period_t,
                                     input logic [DATA_W-1:0] dline_t);
    if (int'(slot) < NUM_SLOTS) begin
      exec_tab[slot]     = exec_t;
      period_tab[slot]   = (period_t == '0) ? DATA_W'(1) : period_t;
      deadline_tab[slot] = dline_t;
      work_tab[slot]     = '0;
      slack_tab[slot]    = 0;
      phase_tab[slot]    = '0;
    end
  endfunction

  // One tick has three steps. It releases the active slots whose phase has run
  // out, runs the ready slot with the least slack (the lowest index wins a tie),
  // and then ages every active slot by one tick.
  function automatic sched_decision_t sched_tick();
    int              n;
    int              best_slack;
    sched_decision_t d;
    n = (int'(task_cnt_q) > NUM_SLOTS) ? NUM_SLOTS : int'(task_cnt_q);
    d = '0;
    best_slack = 0;
    for (int i = 0; i < n; i++) begin
      if (phase_tab[i] == '0) begin
        work_tab[i]  = exec_tab[i];
        slack_tab[i] = int'(deadline_tab[i]);
        phase_tab[i] = (period_tab[i] == '0) ? DATA_W'(1) : period_tab[i];
      end
    end
    for (int i = 0; i < n; i++) begin
      if (work_tab[i] != '0 && (!d.busy || slack_tab[i] < best_slack)) begin
        d.busy     = 1'b1;
        d.slot     = SLOT_W'(i);
        best_slack = slack_tab[i];
      end
    end
    if (d.busy) begin
      work_tab[d.slot] = work_tab[d.slot] - 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      if (slack_tab[i] > SLACK_FLOOR) begin
        slack_tab[i]--;
      end
      phase_tab[i] = phase_tab[i] - 1'b1;
    end
    return d;
  endfunction

  // Only the first ten failures are printed. Later ones are only counted.
  function automatic void log_failure(input string msg);
    if (fail_count < 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    fail_count++;
  endfunction

  // The request is offered until the block takes it. The prediction is made at the
  // edge where it is accepted. On a typed row the hand-written decision is queued
  // in place of the predicted one, but the predictor still advances its state.
  task automatic offer_request(input logic              op,
                               input logic [SLOT_W-1:0] slot,
                               input logic [DATA_W-1:0] exec_t,
                               input logic [DATA_W-1:0] period_t,
                               input logic [DATA_W-1:0] dline_t,
                               input logic              typed,
                               input sched_decision_t   typed_d);
    sched_decision_t d;
    req_if.valid        <= 1'b1;
    req_if.op           <= op;
    req_if.task_slot    <= slot;
    req_if.exec_time    <= exec_t;
    req_if.period_ticks <= period_t;
    req_if.rel_deadline <= dline_t;
    @(posedge clk_i);
    while (!req_if.ready) begin
      @(posedge clk_i);
    end
    if (op == OP_TICK) begin
      d = sched_tick();
      decision_q.push_back(typed ? typed_d : d);
    end else begin
      sched_load(slot, exec_t, period_t, dline_t);
    end
  endtask

  // Sometimes the sender goes quiet for a short random burst between requests.
  task automatic pace_sender();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // The sender pauses until every predicted decision has been returned. It then
  // waits long enough that a trailing load has also finished.
  task automatic settle();
    req_if.valid <= 1'b0;
    while (decision_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // task_count is written only while the block is idle.
  task automatic write_task_count(input logic [CNT_W-1:0] cnt);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cnt;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    task_cnt_q   = cnt;
  endtask

  // This is the result side. Each accepted result is checked against the oldest
  // prediction. The ready signal is then driven for the next edge. It idles in
  // random bursts, except during the long hold-off, which is counted here in
  // cycles.
  initial begin
    sched_decision_t want;
    rsp_if.ready <= 1'b0;
    hold_off_left = 0;
    stall_left    = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        if (decision_q.size() == 0) begin
          log_failure($sformatf("result busy=%0b slot=%0d with no request pending",
                                rsp_if.cpu_busy, rsp_if.running_slot));
        end else begin
          want = decision_q.pop_front();
          if (rsp_if.cpu_busy !== want.busy) begin
            log_failure($sformatf("cpu_busy expected %0b got %0b",
                                  want.busy, rsp_if.cpu_busy));
          end
          if (rsp_if.running_slot !== want.slot) begin
            log_failure($sformatf("running_slot expected %0d got %0d",
                                  want.slot, rsp_if.running_slot));
          end
        end
      end
      if (hold_off_req) begin
        hold_off_req  = 1'b0;
        hold_off_left = HOLD_OFF_CYCLES;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left   = $urandom_range(0, 4);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // The whole run is bounded by a cycle counter, so a hung handshake still ends it.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // This is the request side, which also drives reset and the configuration port.
  initial begin
    dir_row_t          row;
    sched_decision_t   typed_d;
    logic [CNT_W-1:0]  cnt;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] exec_t;
    logic [DATA_W-1:0] period_t;
    logic [DATA_W-1:0] dline_t;

    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_wdata_i         <= '0;
    req_if.valid        <= 1'b0;
    req_if.op           <= OP_LOAD;
    req_if.task_slot    <= '0;
    req_if.exec_time    <= '0;
    req_if.period_ticks <= '0;
    req_if.rel_deadline <= '0;
    fail_count   = 0;
    cycle_cnt    = 0;
    idle_on      = 1'b1;
    hold_off_req = 1'b0;
    task_cnt_q   = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      exec_tab[i]     = '0;
      period_tab[i]   = '0;
      deadline_tab[i] = '0;
      work_tab[i]     = '0;
      slack_tab[i]    = 0;
      phase_tab[i]    = '0;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The directed table comes first.
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIR_TABLE[r];
      if (row.kind == ROW_CFG) begin
        write_task_count(row.cnt);
      end else begin
        typed_d.busy = row.exp_busy;
        typed_d.slot = row.exp_slot;
        pace_sender();
        offer_request((row.kind == ROW_TICK) ? OP_TICK : OP_LOAD, row.slot, row.exec_t,
                      row.period_t, row.dline_t, row.typed, typed_d);
      end
    end

    // In the random phases about three requests in four are ticks. Loads mostly
    // carry short work, short periods and tight deadlines, so that slots compete
    // and deadlines pass. Now and then a load has full-scale values or a zero
    // period. The first phase starts with the long receiver hold-off. The last
    // phase runs with no idling on either side.
    typed_d = '0;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      cnt = (phase < 6) ? CNT_PLAN[phase] : CNT_W'($urandom_range(0, 15));
      write_task_count(cnt);
      idle_on = (phase != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
      if (phase == 0) begin
        hold_off_req = 1'b1;
      end
      for (int k = 0; k < REQS_PER_PHASE; k++) begin
        pace_sender();
        if ($urandom_range(0, 3) == 0) begin
          slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
          case ($urandom_range(0, 19))
            0:       exec_t = DATA_W'($urandom_range(0, 65535));
            1, 2, 3: exec_t = DATA_W'($urandom_range(0, 20));
            default: exec_t = DATA_W'($urandom_range(0, 4));
          endcase
          case ($urandom_range(0, 9))
            0:       period_t = '0;
            1:       period_t = DATA_W'($urandom_range(0, 65535));
            default: period_t = DATA_W'($urandom_range(1, 12));
          endcase
          if ($urandom_range(0, 9) < 2) begin
            dline_t = DATA_W'($urandom_range(0, 65535));
          end else begin
            dline_t = DATA_W'($urandom_range(0, 15));
          end
          offer_request(OP_LOAD, slot, exec_t, period_t, dline_t, 1'b0, typed_d);
        end else begin
          // A tick ignores the load fields, so they carry random values here.
          offer_request(OP_TICK, SLOT_W'($urandom_range(0, 7)),
                        DATA_W'($urandom_range(0, 65535)),
                        DATA_W'($urandom_range(0, 65535)),
                        DATA_W'($urandom_range(0, 65535)), 1'b0, typed_d);
        end
      end
    end

    settle();
    if (fail_count == 0 && decision_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> edf_periodic_task_scheduler_top.f
src/edf_pkg.sv
src/edf_req_if.sv
src/edf_rsp_if.sv
src/edf_ctrl.sv
src/edf_dp.sv
src/edf_periodic_task_scheduler_top.sv
tb/sv/edf_periodic_task_scheduler_top_tb.sv
